@@ rtl/wstk_pkg.sv @@
`default_nettype none
package wstk_pkg;

  localparam int TOP_K_DEF = 5;

  localparam int ID_W    = 32;
  localparam int BASE_W  = 31;
  localparam int CNT_W   = 16;
  localparam int WGT_W   = 8;
  localparam int PROD_W  = CNT_W + WGT_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SCORE_W = 32;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WGT_W-1:0] WEIGHT_A_RST = 8'd50;
  localparam logic [WGT_W-1:0] WEIGHT_B_RST = 8'd5;
  localparam logic [WGT_W-1:0] WEIGHT_C_RST = 8'd10;
  localparam logic [WGT_W-1:0] WEIGHT_D_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_A = 2'd0,
    REG_WEIGHT_B = 2'd1,
    REG_WEIGHT_C = 2'd2,
    REG_WEIGHT_D = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WGT_W-1:0] a;
    logic [WGT_W-1:0] b;
    logic [WGT_W-1:0] c;
    logic [WGT_W-1:0] d;
  } weights_t;

  typedef struct packed {
    logic               final_rec;
    logic [CNT_W-1:0]   count_d;
    logic [CNT_W-1:0]   count_c;
    logic [CNT_W-1:0]   count_b;
    logic [CNT_W-1:0]   count_a;
    logic [BASE_W-1:0]  base_value;
    logic [ID_W-1:0]    rec_id;
  } rec_in_t;

  // scored record leaving the score pipe
  typedef struct packed {
    logic                      valid;
    logic                      final_rec;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } scored_t;

  // record broadcast to every cell
  typedef struct packed {
    logic                      fire;
    logic                      final_rec;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } ins_t;

  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } slot_t;

  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } drain_t;

endpackage
`default_nettype wire

@@ rtl/wstk_score.sv @@
`default_nettype none
module wstk_score (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              rec_valid,
  input  wire wstk_pkg::rec_in_t rec,
  input  wire wstk_pkg::weights_t weights,
  output wstk_pkg::scored_t      scored
);
  import wstk_pkg::*;

  // stage 1: four products
  logic              s1_valid_r;
  logic              s1_final_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [BASE_W-1:0] s1_base_r;
  logic [PROD_W-1:0] s1_pa_r, s1_pb_r, s1_pc_r, s1_pd_r;

  // stage 2: sum minus base
  scored_t s2_r;
  logic [SUM_W-1:0]   sum;
  logic [SCORE_W-1:0] score_nxt;

  always_comb begin
    sum = SUM_W'(s1_pa_r) + SUM_W'(s1_pb_r) + SUM_W'(s1_pc_r) + SUM_W'(s1_pd_r);
    score_nxt = SCORE_W'(sum) - SCORE_W'(s1_base_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_r.valid   <= 1'b0;
    end else if (advance) begin
      s1_valid_r     <= rec_valid;
      s1_final_r     <= rec.final_rec;
      s1_id_r        <= rec.rec_id;
      s1_base_r      <= rec.base_value;
      s1_pa_r        <= PROD_W'(weights.a) * PROD_W'(rec.count_a);
      s1_pb_r        <= PROD_W'(weights.b) * PROD_W'(rec.count_b);
      s1_pc_r        <= PROD_W'(weights.c) * PROD_W'(rec.count_c);
      s1_pd_r        <= PROD_W'(weights.d) * PROD_W'(rec.count_d);
      s2_r.valid     <= s1_valid_r;
      s2_r.final_rec <= s1_final_r;
      s2_r.id        <= s1_id_r;
      s2_r.score     <= $signed(score_nxt);
    end
  end

  assign scored = s2_r;

endmodule
`default_nettype wire

@@ rtl/wstk_cell.sv @@
`default_nettype none
module wstk_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wstk_pkg::ins_t    ins,
  input  wire logic              prev_above,
  input  wire wstk_pkg::slot_t   prev_slot,
  input  wire logic              next_nxt_valid,
  input  wire wstk_pkg::drain_t  next_drain,
  input  wire logic              pop,
  output logic                   above,
  output wstk_pkg::slot_t        slot,
  output wstk_pkg::slot_t        slot_nxt,
  output wstk_pkg::drain_t       drain
);
  import wstk_pkg::*;

  slot_t  slot_r;
  drain_t drain_r;

  // new record ranks above this entry (an empty entry loses to anything)
  always_comb begin
    above = !slot_r.valid || (ins.score > slot_r.score) ||
            ((ins.score == slot_r.score) && (ins.id > slot_r.id));
  end

  // contents after insertion: shift down, take the new record, or keep
  always_comb begin
    if (prev_above) begin
      slot_nxt = prev_slot;
    end else if (above) begin
      slot_nxt.valid = 1'b1;
      slot_nxt.id    = ins.id;
      slot_nxt.score = ins.score;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid  <= 1'b0;
      drain_r.valid <= 1'b0;
    end else begin
      if (ins.fire) begin
        if (ins.final_rec) begin
          slot_r.valid <= 1'b0;
        end else begin
          slot_r <= slot_nxt;
        end
      end
      if (ins.fire && ins.final_rec) begin
        drain_r.valid <= slot_nxt.valid;
        drain_r.last  <= slot_nxt.valid && !next_nxt_valid;
        drain_r.id    <= slot_nxt.id;
        drain_r.score <= slot_nxt.score;
      end else if (pop) begin
        drain_r <= next_drain;
      end
    end
  end

  assign slot  = slot_r;
  assign drain = drain_r;

endmodule
`default_nettype wire

@@ rtl/weighted_score_top_k.sv @@
`default_nettype none
// weighted top-k selector: each request carries a record (id, base value, four counts) and is
// scored as weight_a*count_a + weight_b*count_b + weight_c*count_c + weight_d*count_d - base.
// the TOP_K best records (higher score first, larger id on ties) sit in a row of cells that
// insert one record per cycle. the request flagged by in_tlast is inserted too, then the whole
// row is copied into an output row and cleared, and the entries leave best first with out_tlast
// on the worst one. one request is taken per cycle; scoring takes two pipeline stages and a
// ranked run appears once its final request has been inserted. a final request that reaches
// the row while the previous run is still being sent holds the input until that run is gone,
// so a run shorter than the previous run's result count, or a slow sink, costs stall cycles.
// weights may only be written while the block is idle.
module weighted_score_top_k #(
  parameter int TOP_K = wstk_pkg::TOP_K_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // rec_id[31:0], base_value[62:32], count_a[78:63], count_b[94:79],
  // count_c[110:95], count_d[126:111], zero pad[127]
  input  wire logic [wstk_pkg::IN_DATA_W-1:0]    in_tdata,
  // final_rec
  input  wire logic                              in_tlast,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_id[31:0], out_score[63:32]
  output logic [wstk_pkg::OUT_DATA_W-1:0]        out_tdata,
  // out_last
  output logic                                   out_tlast,
  // weight writes
  input  wire logic                              cfg_we,
  input  wire logic [wstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wstk_pkg::WGT_W-1:0]        cfg_data
);
  import wstk_pkg::*;

  weights_t weights_r;
  rec_in_t  rec;
  scored_t  scored;
  ins_t     ins;
  logic     advance;
  logic     pop;

  slot_t  slot     [TOP_K];
  slot_t  slot_nxt [TOP_K];
  drain_t drain    [TOP_K];
  logic   above    [TOP_K];

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r.a <= WEIGHT_A_RST;
      weights_r.b <= WEIGHT_B_RST;
      weights_r.c <= WEIGHT_C_RST;
      weights_r.d <= WEIGHT_D_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WEIGHT_A: weights_r.a <= cfg_data;
        REG_WEIGHT_B: weights_r.b <= cfg_data;
        REG_WEIGHT_C: weights_r.c <= cfg_data;
        REG_WEIGHT_D: weights_r.d <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the request, pad bit dropped
  assign rec = rec_in_t'({in_tlast, in_tdata[IN_DATA_W-2:0]});

  // hold everything while a final record waits for the output row to empty
  assign advance   = !(scored.valid && scored.final_rec && drain[0].valid);
  assign in_tready = advance;

  wstk_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rec_valid (in_tvalid),
    .rec       (rec),
    .weights   (weights_r),
    .scored    (scored)
  );

  // broadcast to the row
  always_comb begin
    ins.fire      = scored.valid && advance;
    ins.final_rec = scored.final_rec;
    ins.id        = scored.id;
    ins.score     = scored.score;
  end

  assign pop = out_tvalid && out_tready;

  // row of cells, best entry in cell 0; a displaced entry moves to the next cell
  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    logic   prev_above;
    slot_t  prev_slot;
    logic   next_nxt_valid;
    drain_t next_drain;

    if (i == 0) begin : g_head
      assign prev_above = 1'b0;
      assign prev_slot  = '0;
    end else begin : g_body
      assign prev_above = above[i-1];
      assign prev_slot  = slot[i-1];
    end

    if (i == TOP_K - 1) begin : g_tail
      assign next_nxt_valid = 1'b0;
      assign next_drain     = '0;
    end else begin : g_mid
      assign next_nxt_valid = slot_nxt[i+1].valid;
      assign next_drain     = drain[i+1];
    end

    wstk_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ins            (ins),
      .prev_above     (prev_above),
      .prev_slot      (prev_slot),
      .next_nxt_valid (next_nxt_valid),
      .next_drain     (next_drain),
      .pop            (pop),
      .above          (above[i]),
      .slot           (slot[i]),
      .slot_nxt       (slot_nxt[i]),
      .drain          (drain[i])
    );
  end

  // head of the output row drives the result channel
  assign out_tvalid = drain[0].valid;
  assign out_tdata  = {drain[0].score, drain[0].id};
  assign out_tlast  = drain[0].last;

endmodule
`default_nettype wire
